// File: rtl/hssa_pkg.sv
package hssa_pkg;

    localparam int HOUR_W = 5;
    localparam int CO_W   = 10;
    localparam int CO2_W  = 16;
    localparam int TEMP_W = 12;
    localparam int HUM_W  = 7;
    localparam int VAL_W  = 17;
    localparam int CH_W   = 2;
    localparam int SLOT_OUT_W = 2;

    localparam int CNT_W       = 12;
    localparam int MAX_SAMPLES = 4095;
    localparam int DEF_RING_SLOTS = 4;

    localparam int SUM_CO_W   = 22;
    localparam int SUM_CO2_W  = 28;
    localparam int SUM_TEMP_W = 24;
    localparam int SUM_HUM_W  = 19;

    localparam int DIV_W     = 28;
    localparam int DIV_CNT_W = 5;

    localparam int AVG_PACK_W = CO_W + CO2_W + TEMP_W + HUM_W;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    typedef logic [CH_W-1:0] t_chan;

    localparam t_chan CH_CO   = 2'd0;
    localparam t_chan CH_CO2  = 2'd1;
    localparam t_chan CH_TEMP = 2'd2;
    localparam t_chan CH_HUM  = 2'd3;

    typedef logic [DIV_W-1:0] t_dword;
    typedef logic signed [VAL_W-1:0] t_val;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [CO_W-1:0]   co_ppm;
        logic [CO2_W-1:0]  co2_ppm;
        logic [TEMP_W-1:0] temp_tenths;
        logic [HUM_W-1:0]  humidity_pct;
    } t_sample;

    typedef struct packed {
        t_chan                 channel;
        t_val                  running_min;
        t_val                  running_max;
        logic                  hour_closed;
        t_val                  closed_average;
        logic [SLOT_OUT_W-1:0] closed_slot;
        logic                  last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAN,
        ST_DIV,
        ST_EMIT,
        ST_FINISH
    } t_state;

endpackage

// File: rtl/hssa_div.sv
module hssa_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [hssa_pkg::DIV_W-1:0]          i_dividend,
    input  logic [hssa_pkg::CNT_W-1:0]          i_divisor,
    output logic                                o_done,
    output logic [hssa_pkg::DIV_W-1:0]          o_quotient
);

    logic                             r_busy;
    logic                             r_done;
    logic [hssa_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [hssa_pkg::DIV_W-1:0]       r_q;
    logic [hssa_pkg::CNT_W-1:0]       r_rem;
    logic [hssa_pkg::CNT_W-1:0]       r_div;

    logic [hssa_pkg::CNT_W:0] rem_sh;
    logic [hssa_pkg::CNT_W:0] diff;
    logic                     ge;

    assign rem_sh = {r_rem, r_q[hssa_pkg::DIV_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_div});
    assign diff   = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= hssa_pkg::DIV_CNT_W'(hssa_pkg::DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[hssa_pkg::DIV_W-2:0], ge};
            r_rem <= ge ? diff[hssa_pkg::CNT_W-1:0] : rem_sh[hssa_pkg::CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

    a_start_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> !o_done)
        else $error("Divider reported done right after a start.");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("Divider reported done while still iterating.");

endmodule

// File: rtl/hssa_core.sv
module hssa_core #(
    parameter int RING_SLOTS = hssa_pkg::DEF_RING_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hssa_pkg::t_sample i_sample,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output hssa_pkg::t_result o_result
);

    localparam int SW = $clog2(RING_SLOTS);
    localparam int EW = (SW < hssa_pkg::SLOT_OUT_W) ? hssa_pkg::SLOT_OUT_W : SW;

    hssa_pkg::t_state n_state;
    hssa_pkg::t_state r_state;

    hssa_pkg::t_sample                  r_smp;
    logic                               r_closing;
    hssa_pkg::t_chan                    r_ch;
    logic [hssa_pkg::HOUR_W-1:0]        r_hour;
    logic [hssa_pkg::CNT_W-1:0]         r_count;
    logic [hssa_pkg::SUM_CO_W-1:0]      r_sum_co;
    logic [hssa_pkg::SUM_CO2_W-1:0]     r_sum_co2;
    logic [hssa_pkg::SUM_TEMP_W-1:0]    r_sum_temp;
    logic [hssa_pkg::SUM_HUM_W-1:0]     r_sum_hum;
    logic                               r_ext_valid;
    logic [SW-1:0]                      r_wslot;
    hssa_pkg::t_val                     r_min [4];
    hssa_pkg::t_val                     r_max [4];
    hssa_pkg::t_val                     r_avg [4];
    logic [hssa_pkg::AVG_PACK_W-1:0]    r_ring [RING_SLOTS];

    logic                               div_start;
    logic                               div_done;
    hssa_pkg::t_dword                   div_dividend;
    hssa_pkg::t_dword                   div_quot;
    logic                               temp_neg;
    logic [hssa_pkg::SUM_TEMP_W-1:0]    temp_mag;
    hssa_pkg::t_val                     q_val;
    hssa_pkg::t_val                     avg_q;
    hssa_pkg::t_val                     smp_val;
    hssa_pkg::t_val                     new_min;
    hssa_pkg::t_val                     new_max;
    logic [EW-1:0]                      slot_ext;
    logic [hssa_pkg::CNT_W-1:0]         base_cnt;
    logic [hssa_pkg::SUM_CO_W-1:0]      base_co;
    logic [hssa_pkg::SUM_CO2_W-1:0]     base_co2;
    logic [hssa_pkg::SUM_TEMP_W-1:0]    base_temp;
    logic [hssa_pkg::SUM_HUM_W-1:0]     base_hum;
    logic                               can_add;
    logic [SW-1:0]                      next_wslot;

    hssa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    assign temp_neg = r_sum_temp[hssa_pkg::SUM_TEMP_W-1];
    assign temp_mag = temp_neg ? (~r_sum_temp + 1'b1) : r_sum_temp;
    assign q_val    = hssa_pkg::t_val'(div_quot[hssa_pkg::VAL_W-1:0]);
    assign avg_q    = (r_ch == hssa_pkg::CH_TEMP && temp_neg) ? -q_val : q_val;

    always_comb begin
        unique case (r_ch)
            hssa_pkg::CH_CO: begin
                div_dividend = hssa_pkg::t_dword'(r_sum_co);
                smp_val      = hssa_pkg::t_val'(r_smp.co_ppm);
            end
            hssa_pkg::CH_CO2: begin
                div_dividend = hssa_pkg::t_dword'(r_sum_co2);
                smp_val      = hssa_pkg::t_val'(r_smp.co2_ppm);
            end
            hssa_pkg::CH_TEMP: begin
                div_dividend = hssa_pkg::t_dword'(temp_mag);
                smp_val      = {{(hssa_pkg::VAL_W - hssa_pkg::TEMP_W)
                                 {r_smp.temp_tenths[hssa_pkg::TEMP_W-1]}},
                                r_smp.temp_tenths};
            end
            default: begin
                div_dividend = hssa_pkg::t_dword'(r_sum_hum);
                smp_val      = hssa_pkg::t_val'(r_smp.humidity_pct);
            end
        endcase
    end

    assign new_min = (!r_ext_valid || smp_val < r_min[r_ch]) ? smp_val : r_min[r_ch];
    assign new_max = (!r_ext_valid || smp_val > r_max[r_ch]) ? smp_val : r_max[r_ch];
    assign slot_ext = EW'(r_wslot);

    assign base_cnt  = r_closing ? '0 : r_count;
    assign base_co   = r_closing ? '0 : r_sum_co;
    assign base_co2  = r_closing ? '0 : r_sum_co2;
    assign base_temp = r_closing ? '0 : r_sum_temp;
    assign base_hum  = r_closing ? '0 : r_sum_hum;
    assign can_add   = (17'(base_cnt) < 17'(hssa_pkg::MAX_SAMPLES));
    assign next_wslot = (r_wslot == SW'(RING_SLOTS - 1)) ? '0 : r_wslot + 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hssa_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = hssa_pkg::ST_CHAN;
            end
            hssa_pkg::ST_CHAN: begin
                n_state = div_start ? hssa_pkg::ST_DIV : hssa_pkg::ST_EMIT;
            end
            hssa_pkg::ST_DIV: begin
                if (div_done) n_state = hssa_pkg::ST_EMIT;
            end
            hssa_pkg::ST_EMIT: begin
                if (i_res_ready) begin
                    n_state = (r_ch == hssa_pkg::CH_HUM) ? hssa_pkg::ST_FINISH
                                                         : hssa_pkg::ST_CHAN;
                end
            end
            default: n_state = hssa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == hssa_pkg::ST_IDLE);
        div_start   = (r_state == hssa_pkg::ST_CHAN) && r_closing && (r_count != '0);
        o_res_valid = (r_state == hssa_pkg::ST_EMIT);
    end

    always_comb begin
        o_result.channel        = r_ch;
        o_result.running_min    = new_min;
        o_result.running_max    = new_max;
        o_result.hour_closed    = r_closing;
        o_result.closed_average = r_avg[r_ch];
        o_result.closed_slot    = r_closing ? slot_ext[hssa_pkg::SLOT_OUT_W-1:0] : '0;
        o_result.last           = (r_ch == hssa_pkg::CH_HUM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hssa_pkg::ST_IDLE;
            r_closing   <= 1'b0;
            r_ch        <= hssa_pkg::CH_CO;
            r_hour      <= '0;
            r_count     <= '0;
            r_sum_co    <= '0;
            r_sum_co2   <= '0;
            r_sum_temp  <= '0;
            r_sum_hum   <= '0;
            r_ext_valid <= 1'b0;
            r_wslot     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                hssa_pkg::ST_IDLE: begin
                    if (i_in_valid) begin
                        r_closing <= (i_sample.hour != r_hour);
                        r_ch      <= hssa_pkg::CH_CO;
                    end
                end
                hssa_pkg::ST_EMIT: begin
                    if (i_res_ready) r_ch <= r_ch + 1'b1;
                end
                hssa_pkg::ST_FINISH: begin
                    if (r_closing) r_wslot <= next_wslot;
                    r_hour      <= r_smp.hour;
                    r_ext_valid <= 1'b1;
                    if (can_add) begin
                        r_count    <= base_cnt + 1'b1;
                        r_sum_co   <= base_co + hssa_pkg::SUM_CO_W'(r_smp.co_ppm);
                        r_sum_co2  <= base_co2 + hssa_pkg::SUM_CO2_W'(r_smp.co2_ppm);
                        r_sum_temp <= base_temp +
                                      {{(hssa_pkg::SUM_TEMP_W - hssa_pkg::TEMP_W)
                                        {r_smp.temp_tenths[hssa_pkg::TEMP_W-1]}},
                                       r_smp.temp_tenths};
                        r_sum_hum  <= base_hum + hssa_pkg::SUM_HUM_W'(r_smp.humidity_pct);
                    end else begin
                        r_count    <= base_cnt;
                        r_sum_co   <= base_co;
                        r_sum_co2  <= base_co2;
                        r_sum_temp <= base_temp;
                        r_sum_hum  <= base_hum;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == hssa_pkg::ST_IDLE && i_in_valid) begin
            r_smp <= i_sample;
        end
        if (r_state == hssa_pkg::ST_CHAN && !div_start) begin
            r_avg[r_ch] <= '0;
        end
        if (r_state == hssa_pkg::ST_DIV && div_done) begin
            r_avg[r_ch] <= avg_q;
        end
        if (r_state == hssa_pkg::ST_EMIT && i_res_ready) begin
            r_min[r_ch] <= new_min;
            r_max[r_ch] <= new_max;
        end
        if (r_state == hssa_pkg::ST_FINISH && r_closing) begin
            r_ring[r_wslot] <= {r_avg[3][hssa_pkg::HUM_W-1:0],
                                r_avg[2][hssa_pkg::TEMP_W-1:0],
                                r_avg[1][hssa_pkg::CO2_W-1:0],
                                r_avg[0][hssa_pkg::CO_W-1:0]};
        end
    end

    a_avg_zero_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_closing || o_result.closed_average == '0))
        else $error("Nonzero average reported for a transaction that closed no hour.");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_result.running_min <= o_result.running_max))
        else $error("Running minimum exceeds running maximum.");

    a_div_only_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hssa_pkg::ST_DIV) |-> r_closing)
        else $error("Divider in use for a transaction that closed no hour.");

endmodule

// File: rtl/hourly_sensor_stats_accumulator_top.sv
// Hourly sensor statistics accumulator.
// The slave stream carries one four-channel sample and the current hour per
// transaction. For each accepted sample the master stream delivers four
// result transactions, one per channel in the order CO, CO2, temperature and
// humidity, and tlast marks the humidity result. Each result carries the
// running minimum and maximum since reset and, when the sample changed the
// hour, the truncated average of the closed hour and the ring slot it went to.
// A sample in the same hour, or one that closes an empty hour, skips the
// divider: the sequencer steps through its channel and emit states for each
// channel. A sample that closes an hour with samples in it also passes
// through the divide state for each channel, since one restoring divider
// produces one quotient bit per cycle and serves the four channels in turn.
// The slave side is not ready while a sample is being worked on.
// Results pass through an output register, so a stalled receiver holds the
// current result and the sequencer waits before producing the next one.
// Synchronous reset clears the hour, the count, the sums, the ring pointer and
// the validity of the extremes; no clearing pass is needed.
module hourly_sensor_stats_accumulator_top #(
    parameter int RING_SLOTS = hssa_pkg::DEF_RING_SLOTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // Fields from bit 0: hour, co_ppm, co2_ppm, temp_tenths, humidity_pct.
    input  logic [hssa_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // Fields from bit 0: channel, running_min, running_max, closed_average,
    // closed_slot.
    output logic [hssa_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // Fields from bit 0: hour_closed.
    output logic                                o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    hssa_pkg::t_sample sample;
    hssa_pkg::t_result result;
    hssa_pkg::t_result r_out;
    logic              r_out_valid;
    logic              res_valid;
    logic              res_ready;

    assign sample.hour         = i_s_axis_tdata[4:0];
    assign sample.co_ppm       = i_s_axis_tdata[14:5];
    assign sample.co2_ppm      = i_s_axis_tdata[30:15];
    assign sample.temp_tenths  = i_s_axis_tdata[42:31];
    assign sample.humidity_pct = i_s_axis_tdata[49:43];

    assign res_ready = !r_out_valid || i_m_axis_tready;

    hssa_core #(
        .RING_SLOTS (RING_SLOTS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_sample    (sample),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.closed_slot, r_out.closed_average,
                              r_out.running_max, r_out.running_min, r_out.channel};
    assign o_m_axis_tuser  = r_out.hour_closed;
    assign o_m_axis_tlast  = r_out.last;

endmodule

// File: tb/sv/tb_hourly_sensor_stats_accumulator_top.sv
`timescale 1ns / 1ps

class sensor_stats_scoreboard;
    logic [hssa_pkg::HOUR_W-1:0]            cur_hour;
    logic [hssa_pkg::CNT_W-1:0]             cnt;
    logic [hssa_pkg::SUM_CO_W-1:0]          sum_co;
    logic [hssa_pkg::SUM_CO2_W-1:0]         sum_co2;
    logic signed [hssa_pkg::SUM_TEMP_W-1:0] sum_temp;
    logic [hssa_pkg::SUM_HUM_W-1:0]         sum_hum;
    hssa_pkg::t_val                         lo_val[4];
    hssa_pkg::t_val                         hi_val[4];
    bit                                     have_extremes;
    hssa_pkg::t_val                         avg_ring[hssa_pkg::DEF_RING_SLOTS][4];
    int                                     next_slot;
    hssa_pkg::t_result                      expected_q[$];
    int                                     samples;
    int                                     closes;
    int                                     capped;
    int                                     checked;
    int                                     mismatches;

    function new();
        cur_hour = '0;
        cnt = '0;
        sum_co = '0;
        sum_co2 = '0;
        sum_temp = '0;
        sum_hum = '0;
        have_extremes = 1'b0;
        next_slot = 0;
        for (int k = 0; k < 4; k++) begin
            lo_val[k] = '0;
            hi_val[k] = '0;
            for (int j = 0; j < hssa_pkg::DEF_RING_SLOTS; j++) begin
                avg_ring[j][k] = '0;
            end
        end
        samples = 0;
        closes = 0;
        capped = 0;
        checked = 0;
        mismatches = 0;
    endfunction

    function void note_sample(hssa_pkg::t_sample s);
        hssa_pkg::t_chan   chan_order[4];
        hssa_pkg::t_val    v[4];
        int                avg[4];
        int                n;
        int                slot;
        bit                closing;
        hssa_pkg::t_result r;
        chan_order = '{hssa_pkg::CH_CO, hssa_pkg::CH_CO2, hssa_pkg::CH_TEMP,
                       hssa_pkg::CH_HUM};
        v[0] = s.co_ppm;
        v[1] = s.co2_ppm;
        v[2] = $signed(s.temp_tenths);
        v[3] = s.humidity_pct;
        avg = '{0, 0, 0, 0};
        slot = 0;
        samples++;
        closing = (s.hour != cur_hour);
        if (closing) begin
            n = int'(cnt);
            if (n != 0) begin
                avg[0] = int'(sum_co) / n;
                avg[1] = int'(sum_co2) / n;
                avg[2] = int'(sum_temp) / n;
                avg[3] = int'(sum_hum) / n;
            end
            slot = next_slot;
            for (int k = 0; k < 4; k++) begin
                avg_ring[slot][k] = hssa_pkg::t_val'(avg[k]);
            end
            next_slot = (slot + 1) % hssa_pkg::DEF_RING_SLOTS;
            cnt = '0;
            sum_co = '0;
            sum_co2 = '0;
            sum_temp = '0;
            sum_hum = '0;
            cur_hour = s.hour;
            closes++;
        end
        if (cnt < hssa_pkg::CNT_W'(hssa_pkg::MAX_SAMPLES)) begin
            sum_co = sum_co + s.co_ppm;
            sum_co2 = sum_co2 + s.co2_ppm;
            sum_temp = sum_temp + v[2];
            sum_hum = sum_hum + s.humidity_pct;
            cnt = cnt + 1'b1;
        end else begin
            capped++;
        end
        for (int k = 0; k < 4; k++) begin
            if (!have_extremes || v[k] < lo_val[k]) lo_val[k] = v[k];
            if (!have_extremes || v[k] > hi_val[k]) hi_val[k] = v[k];
        end
        have_extremes = 1'b1;
        for (int k = 0; k < 4; k++) begin
            r.channel = chan_order[k];
            r.running_min = lo_val[k];
            r.running_max = hi_val[k];
            r.hour_closed = closing;
            r.closed_average = closing ? avg_ring[slot][k] : '0;
            r.closed_slot = hssa_pkg::SLOT_OUT_W'(slot);
            r.last = (chan_order[k] == hssa_pkg::CH_HUM);
            expected_q.push_back(r);
        end
    endfunction

    function void check_result(hssa_pkg::t_result got);
        hssa_pkg::t_result e;
        bit                ok;
        checked++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected result transaction: channel %0d min %0d max %0d",
                         got.channel, got.running_min, got.running_max);
            end
            return;
        end
        e = expected_q.pop_front();
        ok = (got.channel === e.channel) && (got.running_min === e.running_min) &&
             (got.running_max === e.running_max) && (got.hour_closed === e.hour_closed) &&
             (got.closed_average === e.closed_average) &&
             (got.closed_slot === e.closed_slot) && (got.last === e.last);
        if (!ok) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch: exp ch %0d min %0d max %0d closed %0d avg %0d slot %0d last %0d",
                         e.channel, e.running_min, e.running_max, e.hour_closed,
                         e.closed_average, e.closed_slot, e.last);
                $display("          got ch %0d min %0d max %0d closed %0d avg %0d slot %0d last %0d",
                         got.channel, got.running_min, got.running_max, got.hour_closed,
                         got.closed_average, got.closed_slot, got.last);
            end
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_hourly_sensor_stats_accumulator_top;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_s_axis_tvalid;
    logic                             o_s_axis_tready;
    logic [hssa_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready;
    logic [hssa_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                             o_m_axis_tuser;
    logic                             o_m_axis_tlast;

    sensor_stats_scoreboard sb = new();

    bit no_idle;
    bit pressure_req;
    int pressure_holds;

    hourly_sensor_stats_accumulator_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int idle_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic hssa_pkg::t_sample mk(int hour, int co, int co2, int temp, int hum);
        hssa_pkg::t_sample s;
        s.hour = hour[hssa_pkg::HOUR_W-1:0];
        s.co_ppm = co[hssa_pkg::CO_W-1:0];
        s.co2_ppm = co2[hssa_pkg::CO2_W-1:0];
        s.temp_tenths = temp[hssa_pkg::TEMP_W-1:0];
        s.humidity_pct = hum[hssa_pkg::HUM_W-1:0];
        return s;
    endfunction

    task automatic send(hssa_pkg::t_sample s);
        int g;
        g = idle_gap();
        if (g > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {6'b0, s.humidity_pct, s.temp_tenths, s.co2_ppm, s.co_ppm, s.hour};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_sample(s);
    endtask

    initial begin
        int                stall;
        bit                rdy;
        hssa_pkg::t_result got;
        stall = 0;
        rdy = 1'b0;
        pressure_holds = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rdy && o_m_axis_tvalid) begin
                got.channel = o_m_axis_tdata[1:0];
                got.running_min = o_m_axis_tdata[18:2];
                got.running_max = o_m_axis_tdata[35:19];
                got.closed_average = o_m_axis_tdata[52:36];
                got.closed_slot = o_m_axis_tdata[54:53];
                got.hour_closed = o_m_axis_tuser;
                got.last = o_m_axis_tlast;
                sb.check_result(got);
                stall = idle_gap();
            end
            if (pressure_req) begin
                pressure_req = 1'b0;
                stall = 600;
                pressure_holds++;
            end
            rdy = (stall == 0);
            if (stall > 0) stall--;
            i_m_axis_tready <= rdy;
        end
    end

    initial begin
        int                cur_hour;
        int                r;
        hssa_pkg::t_sample s;
        no_idle = 1'b0;
        pressure_req = 1'b0;
        i_rst_n <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first sample changes the hour from its reset value with nothing counted.
        send(mk(5, 0, 0, -400, 0));
        send(mk(5, 1000, 65535, 1250, 100));
        send(mk(5, 500, 400, 215, 45));
        send(mk(6, 3, 7, -400, 1));
        send(mk(6, 4, 9, -399, 2));
        send(mk(7, 1, 1, 0, 0));
        send(mk(24, 1023, 65535, 2047, 127));
        send(mk(31, 0, 0, -2048, 0));
        send(mk(31, 682, 43690, -1366, 85));
        send(mk(0, 341, 21845, 1365, 42));
        send(mk(1, 10, 20, -1, 30));
        send(mk(2, 11, 21, 1, 31));
        send(mk(3, 12, 22, -2, 32));
        send(mk(4, 13, 23, 2, 33));
        send(mk(4, 14, 24, -3, 34));
        send(mk(23, 999, 60000, 1000, 99));
        send(mk(16, 1, 2, -5, 3));

        cur_hour = 16;
        for (int i = 0; i < 443; i++) begin
            no_idle = ((i / 60) % 4 == 3);
            if (i == 100 || i == 330) pressure_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r >= 97) cur_hour = $urandom_range(0, 31);
            else if (r >= 85) cur_hour = (cur_hour + 1) % 24;
            if ($urandom_range(0, 9) == 0) begin
                s = mk(cur_hour, $urandom, $urandom, $urandom, $urandom);
            end else begin
                s = mk(cur_hour, $urandom_range(0, 1000), $urandom_range(0, 65535),
                       $urandom_range(0, 1650) - 400, $urandom_range(0, 100));
            end
            send(s);
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Run covered %0d samples, %0d hour closes, %0d samples past the count limit,",
                 sb.samples, sb.closes, sb.capped);
        $display("%0d result transactions checked, %0d long receiver hold-offs, %0d mismatches.",
                 sb.checked, pressure_holds, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Timeout with %0d results still expected.", sb.pending());
        $display("Regression FAIL");
        $finish;
    end

endmodule
